>>> hw/rtl/lmsanc_pkg.sv
// ----------------------------------------------------------------------------
// lmsanc_pkg
// Shared constants for the LMS adaptive noise canceller: default sizes,
// fixed-point formats and configuration register indexes.
// ----------------------------------------------------------------------------
package lmsanc_pkg;

    // default sizes of the filter
    localparam int MAX_TAPS_DEF    = 64;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int WEIGHT_BITS_DEF = 32;

    // fixed-point formats
    localparam int STEP_BITS       = 16;  // step size register width
    localparam int MU_FRAC         = 16;  // fraction bits of the step size
    localparam int WEIGHT_INT_BITS = 5;   // integer bits of a weight (Q5.27)
    localparam int ORDER_BITS      = 6;   // tap order register width

    // configuration port
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = STEP_BITS;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_STEP_SIZE = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TAP_ORDER = 2'd1;

endpackage

>>> hw/rtl/lms_adaptive_noise_canceller.sv
// ----------------------------------------------------------------------------
// lms_adaptive_noise_canceller
// LMS adaptive FIR noise canceller built around one shared multiplier.
// ----------------------------------------------------------------------------
// Usage:
//  - s_ channel: one word per sample, tdata = {desired_sample, ref_sample},
//    tlast marks the final sample of a record.
//  - m_ channel: one word per input word, tdata = {filter_out, error_out},
//    tlast echoes the input tlast.
//  - cfg channel: register writes (step size, tap order), taken any time;
//    write them only while no sample is in flight.
//  - Each sample is worked on alone. With T = min(tap_order + 1, MAX_TAPS)
//    taps, a sample takes one pass of the multiplier over the taps for the
//    estimate and a second pass for the weight updates, each pass one tap
//    per cycle plus the pipeline drain.
//  - Warm-up samples (fewer than T samples in the record) skip both passes
//    and give zero outputs.
//  - The result sits in an output register, so the next sample is accepted
//    while it waits; a stalled receiver holds the block only when a second
//    result is ready.
//  - Reset clears weights (through per-tap valid bits), sample count and
//    the configuration registers; no clearing pass is needed. A word with
//    tlast clears weights and count once its result is loaded.
// ----------------------------------------------------------------------------
module lms_adaptive_noise_canceller #(
    parameter int MAX_TAPS    = lmsanc_pkg::MAX_TAPS_DEF,
    parameter int SAMPLE_BITS = lmsanc_pkg::SAMPLE_BITS_DEF,
    parameter int WEIGHT_BITS = lmsanc_pkg::WEIGHT_BITS_DEF
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    // input samples
    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    // fields from bit 0: ref_sample, desired_sample, zero pad
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]       s_tdata,
    input  logic                                     s_tlast,   // last_sample
    // results
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    // fields from bit 0: error_out, filter_out, zero pad
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]       m_tdata,
    output logic                                     m_tlast,   // last_out
    // configuration writes
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [lmsanc_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [lmsanc_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

    import lmsanc_pkg::*;

    // ------------------------------------------------------------------
    // derived sizes
    // ------------------------------------------------------------------
    localparam int S       = SAMPLE_BITS;
    localparam int W       = WEIGHT_BITS;
    localparam int DATA_W  = ((2*S+7)/8)*8;
    localparam int IDX_W   = $clog2(MAX_TAPS);
    localparam int CNT_W   = $clog2(MAX_TAPS+1);
    localparam int TAPW    = (CNT_W > ORDER_BITS+1) ? CNT_W : ORDER_BITS+1;
    localparam int MUE_W   = S + STEP_BITS + 1;
    localparam int A_W     = (W > MUE_W) ? W : MUE_W;
    localparam int P_W     = A_W + S;
    localparam int ACC_W   = W + S + IDX_W;
    localparam int WFRAC   = W - WEIGHT_INT_BITS;
    localparam int YW_W    = ACC_W - WFRAC;
    localparam int SFRAC   = S - 1;
    localparam int UPD_SH  = MU_FRAC + 2*SFRAC - WFRAC - 1;
    localparam int RSH     = (UPD_SH > 0) ? UPD_SH : 0;
    localparam int RSH_M1  = (RSH > 0) ? RSH - 1 : 0;
    localparam int LSH     = (UPD_SH < 0) ? -UPD_SH : 0;
    localparam int DELTA_W = P_W + LSH + 1;
    localparam int SUM_W   = DELTA_W + 1;

    localparam logic signed [ACC_W-1:0] ACC_HALF =
        {{(ACC_W-1){1'b0}}, 1'b1} << (WFRAC - 1);
    localparam logic signed [DELTA_W-1:0] UPD_HALF =
        (RSH > 0) ? ({{(DELTA_W-1){1'b0}}, 1'b1} << RSH_M1) : '0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_RND,
        ST_ERR,
        ST_MUE,
        ST_MUEW,
        ST_UPD,
        ST_DONE
    } state_t;

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    state_t                    state_reg, state_next;
    logic [IDX_W-1:0]          head_reg, head_next;
    logic [CNT_W-1:0]          seen_reg, seen_next;
    logic [STEP_BITS-1:0]      step_reg, step_next;
    logic [ORDER_BITS-1:0]     order_reg, order_next;
    logic [CNT_W-1:0]          taps_reg, taps_next;
    logic [IDX_W-1:0]          base_reg, base_next;
    logic [IDX_W-1:0]          xaddr_reg, xaddr_next;
    logic [IDX_W-1:0]          j_reg, j_next;
    logic [CNT_W-1:0]          rem_reg, rem_next;
    logic                      v1_reg, v1_next;
    logic                      v2_reg, v2_next;
    logic                      v3_reg, v3_next;
    logic [IDX_W-1:0]          j1_reg, j1_next;
    logic [IDX_W-1:0]          j2_reg, j2_next;
    logic [IDX_W-1:0]          j3_reg, j3_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic signed [YW_W-1:0]    yw_reg, yw_next;
    logic signed [S-1:0]       d_reg, d_next;
    logic                      last_reg, last_next;
    logic signed [S-1:0]       e_reg, e_next;
    logic signed [S-1:0]       y_reg, y_next;
    logic signed [MUE_W-1:0]   mue_reg, mue_next;
    logic signed [W-1:0]       w_d2_reg, w_d2_next;
    logic signed [W-1:0]       w_d3_reg, w_d3_next;
    logic signed [DELTA_W-1:0] delta_reg, delta_next;
    logic                      m_valid_reg, m_valid_next;
    logic signed [S-1:0]       m_e_reg, m_e_next;
    logic signed [S-1:0]       m_y_reg, m_y_next;
    logic                      m_last_reg, m_last_next;

    // memories and their read registers
    logic signed [S-1:0]       dline_mem [MAX_TAPS];
    logic signed [W-1:0]       wt_mem [MAX_TAPS];
    logic [MAX_TAPS-1:0]       wt_valid_reg;
    logic signed [S-1:0]       x_rd_reg;
    logic signed [W-1:0]       w_raw_reg;
    logic                      w_vld_reg;

    // ------------------------------------------------------------------
    // combinational helpers
    // ------------------------------------------------------------------
    logic signed [S-1:0]       s_ref;
    logic signed [S-1:0]       s_des;
    logic                      accept;
    logic                      rd_issue;
    logic                      wr_en;
    logic                      wt_clear;
    logic                      mul_en;
    logic signed [A_W-1:0]     mul_a;
    logic signed [S-1:0]       mul_b;
    logic signed [P_W-1:0]     prod;
    logic signed [W-1:0]       w_rd;
    logic signed [W-1:0]       w_new;
    logic [TAPW-1:0]           ord_plus;
    logic [TAPW-1:0]           taps_lim;
    logic [CNT_W-1:0]          taps_cur;
    logic [CNT_W-1:0]          taps_m1;
    logic [IDX_W-1:0]          tm1;
    logic [IDX_W-1:0]          head_inc;
    logic [CNT_W-1:0]          seen_inc;
    logic [IDX_W-1:0]          base_cur;
    logic [IDX_W:0]            base_wrap;
    logic [IDX_W-1:0]          xaddr_inc;
    logic signed [ACC_W-1:0]   acc_rnd;
    logic signed [YW_W:0]      diff;
    logic signed [DELTA_W-1:0] upd_tmp;
    logic signed [DELTA_W-1:0] upd_shr;
    logic signed [SUM_W-1:0]   w_sum;

    assign s_ref    = s_tdata[S-1:0];
    assign s_des    = s_tdata[2*S-1:S];
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = DATA_W'({m_y_reg, m_e_reg});
    assign m_tlast  = m_last_reg;

    assign w_rd = w_vld_reg ? w_raw_reg : '0;

    // taps in use, pointers and start address of the oldest tap
    always_comb begin
        ord_plus  = TAPW'(order_reg) + TAPW'(1);
        taps_lim  = (ord_plus > TAPW'(MAX_TAPS)) ? TAPW'(MAX_TAPS) : ord_plus;
        taps_cur  = taps_lim[CNT_W-1:0];
        taps_m1   = taps_cur - CNT_W'(1);
        tm1       = taps_m1[IDX_W-1:0];
        head_inc  = (head_reg == IDX_W'(MAX_TAPS-1)) ? '0 : head_reg + IDX_W'(1);
        seen_inc  = (seen_reg == CNT_W'(MAX_TAPS)) ? seen_reg : seen_reg + CNT_W'(1);
        base_wrap = {1'b0, head_inc} + (IDX_W+1)'(MAX_TAPS) - {1'b0, tm1};
        base_cur  = (head_inc >= tm1) ? (head_inc - tm1) : base_wrap[IDX_W-1:0];
        xaddr_inc = (xaddr_reg == IDX_W'(MAX_TAPS-1)) ? '0 : xaddr_reg + IDX_W'(1);
    end

    // estimate rounding, error and weight update arithmetic
    always_comb begin
        acc_rnd = acc_reg + ACC_HALF;
        diff    = (YW_W+1)'(d_reg) - (YW_W+1)'(yw_reg);
        upd_tmp = DELTA_W'(prod) + UPD_HALF;
        upd_shr = (upd_tmp >>> RSH) <<< LSH;
        w_sum   = SUM_W'(w_d3_reg) + SUM_W'(delta_reg);
        // saturate the updated weight
        if (&w_sum[SUM_W-1:W-1] || ~(|w_sum[SUM_W-1:W-1])) begin
            w_new = w_sum[W-1:0];
        end else if (w_sum[SUM_W-1]) begin
            w_new = {1'b1, {(W-1){1'b0}}};
        end else begin
            w_new = {1'b0, {(W-1){1'b1}}};
        end
    end

    // shared multiplier
    lmsanc_mul #(
        .A_BITS (A_W),
        .B_BITS (S)
    ) u_mul (
        .aclk (aclk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .p    (prod)
    );

    // ------------------------------------------------------------------
    // sequencer next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next   = state_reg;
        head_next    = head_reg;
        seen_next    = seen_reg;
        step_next    = step_reg;
        order_next   = order_reg;
        taps_next    = taps_reg;
        base_next    = base_reg;
        xaddr_next   = xaddr_reg;
        j_next       = j_reg;
        rem_next     = rem_reg;
        v1_next      = 1'b0;
        v2_next      = 1'b0;
        v3_next      = 1'b0;
        j1_next      = j1_reg;
        j2_next      = j2_reg;
        j3_next      = j3_reg;
        acc_next     = acc_reg;
        yw_next      = yw_reg;
        d_next       = d_reg;
        last_next    = last_reg;
        e_next       = e_reg;
        y_next       = y_reg;
        mue_next     = mue_reg;
        w_d2_next    = w_d2_reg;
        w_d3_next    = w_d3_reg;
        delta_next   = delta_reg;
        m_valid_next = m_valid_reg;
        m_e_next     = m_e_reg;
        m_y_next     = m_y_reg;
        m_last_next  = m_last_reg;
        rd_issue     = 1'b0;
        wr_en        = 1'b0;
        wt_clear     = 1'b0;
        mul_en       = 1'b0;
        mul_a        = '0;
        mul_b        = '0;

        // configuration writes
        if (cfg_valid) begin
            case (cfg_index)
                CFG_STEP_SIZE: step_next  = cfg_data[STEP_BITS-1:0];
                CFG_TAP_ORDER: order_next = cfg_data[ORDER_BITS-1:0];
                default: ;
            endcase
        end

        // result taken by the receiver
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    head_next  = head_inc;
                    seen_next  = seen_inc;
                    taps_next  = taps_cur;
                    base_next  = base_cur;
                    xaddr_next = base_cur;
                    j_next     = '0;
                    rem_next   = taps_cur;
                    d_next     = s_des;
                    last_next  = s_tlast;
                    acc_next   = '0;
                    if (seen_inc >= taps_cur) begin
                        state_next = ST_MAC;
                    end else begin
                        e_next     = '0;
                        y_next     = '0;
                        state_next = ST_DONE;
                    end
                end
            end

            // dot product pass: read, multiply, accumulate
            ST_MAC: begin
                if (rem_reg != '0) begin
                    rd_issue   = 1'b1;
                    rem_next   = rem_reg - CNT_W'(1);
                    j_next     = j_reg + IDX_W'(1);
                    xaddr_next = xaddr_inc;
                end
                v1_next = rd_issue;
                if (v1_reg) begin
                    mul_en = 1'b1;
                    mul_a  = A_W'(w_rd);
                    mul_b  = x_rd_reg;
                end
                v2_next = v1_reg;
                if (v2_reg) begin
                    acc_next = acc_reg + ACC_W'($signed(prod[W+S-1:0]));
                end
                if (rem_reg == '0 && !v1_reg && !v2_reg) begin
                    state_next = ST_RND;
                end
            end

            // round the estimate to sample precision
            ST_RND: begin
                yw_next    = acc_rnd[ACC_W-1:WFRAC];
                state_next = ST_ERR;
            end

            // saturated error and estimate
            ST_ERR: begin
                if (&diff[YW_W:S-1] || ~(|diff[YW_W:S-1])) begin
                    e_next = diff[S-1:0];
                end else if (diff[YW_W]) begin
                    e_next = {1'b1, {(S-1){1'b0}}};
                end else begin
                    e_next = {1'b0, {(S-1){1'b1}}};
                end
                if (&yw_reg[YW_W-1:S-1] || ~(|yw_reg[YW_W-1:S-1])) begin
                    y_next = yw_reg[S-1:0];
                end else if (yw_reg[YW_W-1]) begin
                    y_next = {1'b1, {(S-1){1'b0}}};
                end else begin
                    y_next = {1'b0, {(S-1){1'b1}}};
                end
                state_next = ST_MUE;
            end

            // step size times error
            ST_MUE: begin
                mul_en     = 1'b1;
                mul_a      = A_W'({1'b0, step_reg});
                mul_b      = e_reg;
                state_next = ST_MUEW;
            end

            ST_MUEW: begin
                mue_next   = prod[MUE_W-1:0];
                rem_next   = taps_reg;
                j_next     = '0;
                xaddr_next = base_reg;
                state_next = ST_UPD;
            end

            // update pass: read, multiply, round, add and write back
            ST_UPD: begin
                if (rem_reg != '0) begin
                    rd_issue   = 1'b1;
                    rem_next   = rem_reg - CNT_W'(1);
                    j_next     = j_reg + IDX_W'(1);
                    xaddr_next = xaddr_inc;
                    j1_next    = j_reg;
                end
                v1_next = rd_issue;
                if (v1_reg) begin
                    mul_en    = 1'b1;
                    mul_a     = A_W'(mue_reg);
                    mul_b     = x_rd_reg;
                    w_d2_next = w_rd;
                    j2_next   = j1_reg;
                end
                v2_next = v1_reg;
                if (v2_reg) begin
                    delta_next = upd_shr;
                    w_d3_next  = w_d2_reg;
                    j3_next    = j2_reg;
                end
                v3_next = v2_reg;
                wr_en   = v3_reg;
                if (rem_reg == '0 && !v1_reg && !v2_reg && !v3_reg) begin
                    state_next = ST_DONE;
                end
            end

            // hand the result to the output register
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_e_next     = e_reg;
                    m_y_next     = y_reg;
                    m_last_next  = last_reg;
                    m_valid_next = 1'b1;
                    if (last_reg) begin
                        wt_clear  = 1'b1;
                        seen_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // state and output registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        taps_reg  <= taps_next;
        base_reg  <= base_next;
        xaddr_reg <= xaddr_next;
        j_reg     <= j_next;
        rem_reg   <= rem_next;
        j1_reg    <= j1_next;
        j2_reg    <= j2_next;
        j3_reg    <= j3_next;
        acc_reg   <= acc_next;
        yw_reg    <= yw_next;
        d_reg     <= d_next;
        last_reg  <= last_next;
        e_reg     <= e_next;
        y_reg     <= y_next;
        mue_reg   <= mue_next;
        w_d2_reg  <= w_d2_next;
        w_d3_reg  <= w_d3_next;
        delta_reg <= delta_next;
        m_e_reg   <= m_e_next;
        m_y_reg   <= m_y_next;
        m_last_reg <= m_last_next;
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            seen_reg    <= '0;
            step_reg    <= '0;
            order_reg   <= '0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            seen_reg    <= seen_next;
            step_reg    <= step_next;
            order_reg   <= order_next;
            v1_reg      <= v1_next;
            v2_reg      <= v2_next;
            v3_reg      <= v3_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // delay line and weight memories, registered reads
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (accept) begin
            dline_mem[head_inc] <= s_ref;
        end
        if (rd_issue) begin
            x_rd_reg  <= dline_mem[xaddr_reg];
            w_raw_reg <= wt_mem[j_reg];
            w_vld_reg <= wt_valid_reg[j_reg];
        end
        if (wr_en) begin
            wt_mem[j3_reg] <= w_new;
        end
    end

    // per-tap valid bits: an invalid weight reads as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wt_valid_reg <= '0;
        end else if (wt_clear) begin
            wt_valid_reg <= '0;
        end else if (wr_en) begin
            wt_valid_reg[j3_reg] <= 1'b1;
        end
    end

endmodule

>>> hw/rtl/lmsanc_mul.sv
// ----------------------------------------------------------------------------
// lmsanc_mul
// Shared signed multiplier with a registered product. Used for the filter
// dot product, the step size times error product and the weight updates.
// ----------------------------------------------------------------------------
module lmsanc_mul #(
    parameter int A_BITS = 33,
    parameter int B_BITS = 16
) (
    input  logic                             aclk,
    input  logic                             en,
    input  logic signed [A_BITS-1:0]         a,
    input  logic signed [B_BITS-1:0]         b,
    output logic signed [A_BITS+B_BITS-1:0]  p
);

    logic signed [A_BITS+B_BITS-1:0] p_reg;

    // product register, loaded only when the sequencer issues an operation
    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg <= a * b;
        end
    end

    assign p = p_reg;

endmodule
